// ===== rtl/pkqb_pkg.sv =====
// Shared types, widths and codes for the per-kind packet queues block.
package pkqb_pkg;

    // Sizing. QUEUE_DEPTH must be a power of two so head pointers wrap by truncation.
    localparam int NUM_KINDS   = 256;
    localparam int QUEUE_DEPTH = 16;
    localparam int KIND_W      = $clog2(NUM_KINDS);
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int META_W      = SLOT_W + CNT_W;

    // Field widths.
    localparam int MODE_W    = 2;
    localparam int IN_KIND_W = 8;
    localparam int TAG_W     = 16;
    localparam int LEN_W     = 17;
    localparam int TOT_W     = 25;
    localparam int DROP_W    = 13;
    localparam int LIMIT_W   = 5;
    localparam int ENT_W     = LEN_W + TAG_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 25;

    // Register reset values and saturation limit.
    localparam logic [TOT_W-1:0]   BUDGET_RESET = 25'd4194304;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd16;
    localparam logic [DROP_W-1:0]  DROP_MAX     = 13'd8191;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [IN_KIND_W-1:0] kind;
        logic [LEN_W-1:0]     pkt_length;
        logic [TAG_W-1:0]     buffer_tag;
    } t_in_req;

    typedef struct packed {
        logic              status;
        logic [TAG_W-1:0]  out_tag;
        logic [LEN_W-1:0]  out_length;
        logic [DROP_W-1:0] dropped_count;
        logic [TOT_W-1:0]  bytes_held;
    } t_out_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic sel_kind;
        logic sel_ptr;
        logic meta_rd;
        logic meta_latch;
        logic ent_rd;
        logic take;
        logic take_pop;
        logic meta_wr;
        logic ent_wr;
        logic scan_inc;
        logic set_empty;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_ge_limit;
        logic cnt_full;
        logic over_budget;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/per_kind_packet_queues_byte_budget.sv =====
// Top level: per-kind descriptor queues under a shared byte budget.
// One request at a time; the next one is taken the cycle after its result is issued.
// A pop takes the head packet of its queue; drain-one drops every descriptor of its queue.
// Enqueue drops from its own queue at the limit or over the budget; a victim search then scans
// the queues in index order and drops from non-empty ones while over budget. Drain-all empties all.
// Synchronous active-low reset clears all queues through per-queue valid bits.
module per_kind_packet_queues_byte_budget (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pkqb_pkg::t_in_req              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pkqb_pkg::t_out_rsp             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pkqb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pkqb_pkg::CFG_W-1:0]     i_cfg_data
);

    pkqb_pkg::t_cmd cmd;
    pkqb_pkg::t_sts sts;

    // Controller.
    pkqb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    pkqb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // The block is busy right after it takes a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // A new result only comes out of a request in progress.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // An empty pop carries no packet and drops nothing.
    a_empty_pop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |->
        (o_out_data.out_tag == '0 && o_out_data.out_length == '0 &&
         o_out_data.dropped_count == '0))
        else $error("empty pop result carries data");
`endif

endmodule

// ===== rtl/pkqb_dp.sv =====
// Datapath: descriptor store, per-queue head and count store, byte total and result register.
module pkqb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pkqb_pkg::t_cmd                      i_cmd,
    output pkqb_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [pkqb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pkqb_pkg::CFG_W-1:0]          i_cfg_data,
    input  pkqb_pkg::t_in_req                   i_in_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output pkqb_pkg::t_out_rsp                  o_out_data
);

    // Configuration registers.
    logic [pkqb_pkg::TOT_W-1:0]   r_budget;
    logic [pkqb_pkg::LIMIT_W-1:0] r_limit;

    // Captured request.
    logic [pkqb_pkg::KIND_W-1:0] r_kind;
    logic [pkqb_pkg::LEN_W-1:0]  r_len;
    logic [pkqb_pkg::TAG_W-1:0]  r_tag;

    // Working copy of the selected queue.
    logic [pkqb_pkg::KIND_W-1:0] r_cur_q;
    logic [pkqb_pkg::KIND_W:0]   r_ptr;
    logic [pkqb_pkg::SLOT_W-1:0] r_head;
    logic [pkqb_pkg::CNT_W-1:0]  r_cnt;

    // Running totals and result fields.
    logic [pkqb_pkg::TOT_W-1:0]  r_total;
    logic [pkqb_pkg::DROP_W-1:0] r_tally;
    logic                        r_status;
    logic [pkqb_pkg::TAG_W-1:0]  r_otag;
    logic [pkqb_pkg::LEN_W-1:0]  r_olen;
    logic                        r_out_valid;
    pkqb_pkg::t_out_rsp          r_out;

    // Memories and their registered read data.
    logic [pkqb_pkg::META_W-1:0] meta_mem [pkqb_pkg::NUM_KINDS];
    logic [pkqb_pkg::ENT_W-1:0]  ent_mem  [pkqb_pkg::NUM_KINDS*pkqb_pkg::QUEUE_DEPTH];
    logic [pkqb_pkg::META_W-1:0] r_meta_rd;
    logic                        r_meta_ok;
    logic [pkqb_pkg::ENT_W-1:0]  r_ent_rd;
    logic [pkqb_pkg::NUM_KINDS-1:0] r_mvalid;
    logic [pkqb_pkg::NUM_KINDS-1:0] r_nonempty;

    logic [pkqb_pkg::CNT_W-1:0]  limit_eff;
    logic [pkqb_pkg::LEN_W-1:0]  ent_len;
    logic [pkqb_pkg::SLOT_W-1:0] tail_slot;
    logic [pkqb_pkg::TOT_W:0]    need_sum;

    // Effective queue limit saturates at the physical queue depth.
    always_comb begin
        if (32'(r_limit) > 32'(pkqb_pkg::QUEUE_DEPTH)) begin
            limit_eff = pkqb_pkg::CNT_W'(pkqb_pkg::QUEUE_DEPTH);
        end else begin
            limit_eff = pkqb_pkg::CNT_W'(r_limit);
        end
    end

    assign ent_len   = r_ent_rd[pkqb_pkg::TAG_W +: pkqb_pkg::LEN_W];
    assign tail_slot = r_head + r_cnt[pkqb_pkg::SLOT_W-1:0];
    assign need_sum  = {1'b0, r_total} + (pkqb_pkg::TOT_W+1)'(r_len);

    // Status toward the controller.
    assign o_sts.cnt_zero     = (r_cnt == '0);
    assign o_sts.cnt_ge_limit = (r_cnt >= limit_eff);
    assign o_sts.cnt_full     = (r_cnt == pkqb_pkg::CNT_W'(pkqb_pkg::QUEUE_DEPTH));
    assign o_sts.over_budget  = (need_sum > {1'b0, r_budget});
    assign o_sts.scan_end     = r_ptr[pkqb_pkg::KIND_W];
    assign o_sts.scan_hit     = !r_ptr[pkqb_pkg::KIND_W] &&
                                r_nonempty[r_ptr[pkqb_pkg::KIND_W-1:0]];
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= pkqb_pkg::BUDGET_RESET;
            r_limit  <= pkqb_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pkqb_pkg::CFG_BUDGET: r_budget <= i_cfg_data[pkqb_pkg::TOT_W-1:0];
                pkqb_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[pkqb_pkg::LIMIT_W-1:0];
                default:              r_limit  <= r_limit;
            endcase
        end
    end

    // Head and count store, read and written at the selected queue.
    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_rd) begin
            r_meta_rd <= meta_mem[r_cur_q];
        end
        if (i_cmd.meta_wr) begin
            meta_mem[r_cur_q] <= {r_head, r_cnt};
        end
    end

    // Valid and non-empty bits per queue; an unwritten queue reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid   <= '0;
            r_nonempty <= '0;
        end else if (i_cmd.meta_wr) begin
            r_mvalid[r_cur_q]   <= 1'b1;
            r_nonempty[r_cur_q] <= (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_rd) begin
            r_meta_ok <= r_mvalid[r_cur_q];
        end
    end

    // Descriptor store: head read for drops and pops, tail write for enqueue.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_ent_rd <= ent_mem[{r_cur_q, r_head}];
        end
        if (i_cmd.ent_wr) begin
            ent_mem[{r_cur_q, tail_slot}] <= {r_len, r_tag};
        end
    end

    // Request capture, queue selection and scan pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_in_data.kind[pkqb_pkg::KIND_W-1:0];
            r_len   <= i_in_data.pkt_length;
            r_tag   <= i_in_data.buffer_tag;
            r_cur_q <= i_in_data.kind[pkqb_pkg::KIND_W-1:0];
            r_ptr   <= '0;
        end else begin
            if (i_cmd.sel_kind) begin
                r_cur_q <= r_kind;
            end else if (i_cmd.sel_ptr) begin
                r_cur_q <= r_ptr[pkqb_pkg::KIND_W-1:0];
            end
            if (i_cmd.scan_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // Working head and count: loaded from the store, moved by take and write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_latch) begin
            if (r_meta_ok) begin
                {r_head, r_cnt} <= r_meta_rd;
            end else begin
                r_head <= '0;
                r_cnt  <= '0;
            end
        end else if (i_cmd.take) begin
            r_head <= r_head + 1'b1;
            r_cnt  <= r_cnt - 1'b1;
        end else if (i_cmd.ent_wr) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Byte total, which is block state and cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.take) begin
            if (r_total >= pkqb_pkg::TOT_W'(ent_len)) begin
                r_total <= r_total - pkqb_pkg::TOT_W'(ent_len);
            end else begin
                r_total <= '0;
            end
        end else if (i_cmd.ent_wr) begin
            r_total <= need_sum[pkqb_pkg::TOT_W-1:0];
        end
    end

    // Per-request result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tally  <= '0;
            r_status <= 1'b0;
            r_otag   <= '0;
            r_olen   <= '0;
        end else begin
            if (i_cmd.set_empty) begin
                r_status <= 1'b1;
            end
            if (i_cmd.take && i_cmd.take_pop) begin
                r_otag <= r_ent_rd[pkqb_pkg::TAG_W-1:0];
                r_olen <= ent_len;
            end else if (i_cmd.take && (r_tally != pkqb_pkg::DROP_MAX)) begin
                r_tally <= r_tally + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= '{status: r_status, out_tag: r_otag, out_length: r_olen,
                       dropped_count: r_tally, bytes_held: r_total};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/pkqb_ctrl.sv =====
// Controller: sequences loads, drops, victim scans and write-back for each request.
module pkqb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [pkqb_pkg::MODE_W-1:0]   i_in_mode,
    output logic                          o_in_stall,
    input  pkqb_pkg::t_sts                i_sts,
    output pkqb_pkg::t_cmd                o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOAD   = 10'b00_0000_0010,
        S_LATCH  = 10'b00_0000_0100,
        S_DECIDE = 10'b00_0000_1000,
        S_RD     = 10'b00_0001_0000,
        S_TAKE   = 10'b00_0010_0000,
        S_STORE  = 10'b00_0100_0000,
        S_SCAN   = 10'b00_1000_0000,
        S_WRITE  = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } t_state;

    // Enqueue phases: limit check, own-queue eviction, victim eviction, final insert.
    typedef enum logic [1:0] {
        PH_LIMIT  = 2'd0,
        PH_BUDGET = 2'd1,
        PH_VICTIM = 2'd2,
        PH_FINAL  = 2'd3
    } t_phase;

    t_state                      r_state, n_state;
    t_state                      r_after, n_after;
    t_phase                      r_phase, n_phase;
    logic [pkqb_pkg::MODE_W-1:0] r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_FINISH;
            r_phase <= PH_LIMIT;
            r_mode  <= pkqb_pkg::MODE_ENQ;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_phase <= n_phase;
            r_mode  <= n_mode;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_phase = r_phase;
        n_mode  = r_mode;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_mode      = i_in_mode;
                    n_phase     = PH_LIMIT;
                    n_state     = (i_in_mode == pkqb_pkg::MODE_ALL) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.meta_rd = 1'b1;
                n_state       = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.meta_latch = 1'b1;
                n_state          = S_DECIDE;
            end
            S_DECIDE: begin
                case (r_mode) inside
                    pkqb_pkg::MODE_POP: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = S_FINISH;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    pkqb_pkg::MODE_ONE, pkqb_pkg::MODE_ALL: begin
                        if (!i_sts.cnt_zero) begin
                            n_state = S_RD;
                        end else begin
                            n_state = S_STORE;
                            n_after = (r_mode == pkqb_pkg::MODE_ONE) ? S_FINISH : S_SCAN;
                        end
                    end
                    default: begin
                        unique case (r_phase)
                            PH_LIMIT: begin
                                n_phase = PH_BUDGET;
                                n_state = (i_sts.cnt_ge_limit && !i_sts.cnt_zero) ?
                                          S_RD : S_DECIDE;
                            end
                            PH_BUDGET: begin
                                if (!i_sts.over_budget) begin
                                    n_phase = PH_FINAL;
                                end else if (!i_sts.cnt_zero) begin
                                    n_state = S_RD;
                                end else begin
                                    n_state = S_STORE;
                                    n_after = S_SCAN;
                                    n_phase = PH_VICTIM;
                                end
                            end
                            PH_VICTIM: begin
                                if (i_sts.over_budget && !i_sts.cnt_zero) begin
                                    n_state = S_RD;
                                end else if (i_sts.over_budget) begin
                                    n_state = S_STORE;
                                    n_after = S_SCAN;
                                end else begin
                                    n_state = S_STORE;
                                    n_after = S_LOAD;
                                    n_phase = PH_FINAL;
                                end
                            end
                            default: begin
                                n_state = i_sts.cnt_full ? S_RD : S_WRITE;
                            end
                        endcase
                    end
                endcase
            end
            S_RD: begin
                o_cmd.ent_rd = 1'b1;
                n_state      = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take     = 1'b1;
                o_cmd.take_pop = (r_mode == pkqb_pkg::MODE_POP);
                if (r_mode == pkqb_pkg::MODE_POP) begin
                    n_state = S_STORE;
                    n_after = S_FINISH;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_STORE: begin
                o_cmd.meta_wr  = 1'b1;
                o_cmd.sel_kind = (r_after == S_LOAD);
                n_state        = r_after;
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    if (r_mode == pkqb_pkg::MODE_ENQ) begin
                        o_cmd.sel_kind = 1'b1;
                        n_phase        = PH_FINAL;
                        n_state        = S_LOAD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (i_sts.scan_hit) begin
                    o_cmd.sel_ptr = 1'b1;
                    n_state       = S_LOAD;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.ent_wr = 1'b1;
                n_state      = S_STORE;
                n_after      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
